// ----- design/cpod_pkg.sv -----
package cpod_pkg;

  // Widths used across the datapath
  localparam int NUM_W = 52;   // divider numerator, signed
  localparam int DEN_W = 34;   // divider denominator, signed
  localparam int PAR_W = 18;   // Q1.16 parameter, signed
  localparam int QB_W  = 17;   // quotient magnitude bits
  localparam int THR_W = 32;
  localparam logic [31:0] THR_RESET = 32'd4295;
  localparam logic signed [PAR_W-1:0] ONE_Q16 = 18'sd65536;

  // Per-request data carried alongside the divider pipelines
  typedef struct packed {
    logic signed [PAR_W-1:0] s;
    logic signed [PAR_W-1:0] t;
    logic                    ft;
    logic                    need3;
    logic [31:0]             a;
    logic signed [32:0]      b;
    logic [31:0]             c;
    logic signed [33:0]      d;
    logic signed [33:0]      e;
    logic signed [16:0]      qx;
    logic signed [16:0]      qy;
    logic signed [15:0]      h1x;
    logic signed [15:0]      h1y;
    logic signed [15:0]      h2x;
    logic signed [15:0]      h2y;
    logic [16:0]             rsum;
  } side_t;

endpackage

// ----- design/cpod_div.sv -----
module cpod_div #(
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [cpod_pkg::NUM_W-1:0]   num,
  input  logic signed [cpod_pkg::DEN_W-1:0]   den,
  input  logic [SIDE_W-1:0]                   side_in,
  output logic                                out_valid,
  output logic signed [cpod_pkg::PAR_W-1:0]   quot,
  output logic                                sat,
  output logic [SIDE_W-1:0]                   side_out
);

  localparam int NST = cpod_pkg::QB_W;

  // Prep: fold signs so the divisor is positive, check saturation
  logic signed [cpod_pkg::NUM_W-1:0] num_adj, num_mag;
  logic signed [cpod_pkg::DEN_W-1:0] den_pos;
  logic [50:0] mag;
  logic [32:0] den_a;
  logic        over, num_neg, den_zero;

  always_comb begin
    den_pos  = den[cpod_pkg::DEN_W-1] ? -den : den;
    num_adj  = den[cpod_pkg::DEN_W-1] ? -num : num;
    num_neg  = num_adj[cpod_pkg::NUM_W-1];
    num_mag  = num_neg ? -num_adj : num_adj;
    mag      = num_mag[50:0];
    den_a    = den_pos[32:0];
    den_zero = (den == '0);
    over     = mag > {2'b00, den_a, 16'b0};
  end

  logic              vld  [0:NST];
  logic              zr   [0:NST];
  logic              ov   [0:NST];
  logic              ng   [0:NST];
  logic [50:0]       rem  [0:NST];
  logic [32:0]       dv   [0:NST];
  logic [NST-1:0]    qb   [0:NST];
  logic [SIDE_W-1:0] sd   [0:NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    zr[0]  <= den_zero;
    ov[0]  <= over;
    ng[0]  <= num_neg;
    rem[0] <= mag;
    dv[0]  <= den_a;
    qb[0]  <= '0;
    sd[0]  <= side_in;
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < NST; j++) begin : g_stage
    localparam int B = NST - 1 - j;
    logic [50:0] shifted;
    logic        take;
    assign shifted = {18'b0, dv[j]} << B;
    assign take    = rem[j] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      zr[j+1]  <= zr[j];
      ov[j+1]  <= ov[j];
      ng[j+1]  <= ng[j];
      dv[j+1]  <= dv[j];
      sd[j+1]  <= sd[j];
      rem[j+1] <= take ? rem[j] - shifted : rem[j];
      qb[j+1]  <= qb[j] | (take ? (NST'(1) << B) : '0);
    end
  end

  // Result: zero divisor gives 0, overflow saturates to +/-1
  logic signed [cpod_pkg::PAR_W-1:0] qmag;
  always_comb begin
    qmag = {1'b0, qb[NST]};
    if (zr[NST]) begin
      quot = '0;
    end else if (ov[NST]) begin
      quot = ng[NST] ? -cpod_pkg::ONE_Q16 : cpod_pkg::ONE_Q16;
    end else begin
      quot = ng[NST] ? -qmag : qmag;
    end
  end

  assign sat       = !zr[NST] && ov[NST];
  assign out_valid = vld[NST];
  assign side_out  = sd[NST];

endmodule

// ----- design/capsule_pair_overlap_distance_top.sv -----
// Capsule pair overlap distance, fully pipelined.
// Request channel: drive the ten capsule fields and pulse start; a request
// is taken at every clock edge with start high and busy low. busy is
// always low, so a new request may enter every cycle.
// Result channel: done is high for exactly one cycle with gap_measure,
// first_param and second_param; the receiver cannot stall, so results
// are never held back.
// Pipeline from start to done: four setup stages, three
// 18-stage saturating dividers in series, each with one stage after it,
// and four distance stages. Throughput: one request per cycle; the three
// divider pipelines, one restoring bit per stage, set the depth.
// Config: write parallel_threshold on cfg_data with cfg_valid; cfg_ready
// is always high. Write only while no request is in flight.
// Reset (synchronous rst) clears all valid bits and sets the threshold to
// 4295; requests in flight are dropped.
module capsule_pair_overlap_distance_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] first_center_x,
  input  logic signed [15:0] first_center_y,
  input  logic signed [15:0] first_half_x,
  input  logic signed [15:0] first_half_y,
  input  logic [15:0]        first_radius,
  input  logic signed [15:0] second_center_x,
  input  logic signed [15:0] second_center_y,
  input  logic signed [15:0] second_half_x,
  input  logic signed [15:0] second_half_y,
  input  logic [15:0]        second_radius,
  output logic               done,
  output logic signed [36:0] gap_measure,
  output logic signed [17:0] first_param,
  output logic signed [17:0] second_param,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int SW = $bits(cpod_pkg::side_t);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Threshold register
  logic [cpod_pkg::THR_W-1:0] thr;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= cpod_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // Stage 1: center difference, radius sum
  logic v1;
  logic signed [16:0] qx1, qy1;
  logic signed [15:0] h1x1, h1y1, h2x1, h2y1;
  logic [16:0] rs1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    qx1  <= 17'(first_center_x) - 17'(second_center_x);
    qy1  <= 17'(first_center_y) - 17'(second_center_y);
    h1x1 <= first_half_x;
    h1y1 <= first_half_y;
    h2x1 <= second_half_x;
    h2y1 <= second_half_y;
    rs1  <= 17'(first_radius) + 17'(second_radius);
  end

  // Stage 2: all pairwise products
  logic v2;
  logic signed [31:0] paa1, paa2, pbb1, pbb2, pcc1, pcc2, pkk1, pkk2;
  logic signed [32:0] pdd1, pdd2, pee1, pee2, px11, px12, px21, px22;
  logic signed [16:0] qx2, qy2;
  logic signed [15:0] h1x2, h1y2, h2x2, h2y2;
  logic [16:0] rs2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    paa1 <= h1x1 * h1x1;
    paa2 <= h1y1 * h1y1;
    pbb1 <= h1x1 * h2x1;
    pbb2 <= h1y1 * h2y1;
    pcc1 <= h2x1 * h2x1;
    pcc2 <= h2y1 * h2y1;
    pkk1 <= h1x1 * h2y1;
    pkk2 <= h1y1 * h2x1;
    pdd1 <= 33'(h1x1) * 33'(qx1);
    pdd2 <= 33'(h1y1) * 33'(qy1);
    pee1 <= 33'(h2x1) * 33'(qx1);
    pee2 <= 33'(h2y1) * 33'(qy1);
    px11 <= 33'(h2x1) * 33'(qy1);
    px12 <= 33'(h2y1) * 33'(qx1);
    px21 <= 33'(h1x1) * 33'(qy1);
    px22 <= 33'(h1y1) * 33'(qx1);
    qx2 <= qx1; qy2 <= qy1;
    h1x2 <= h1x1; h1y2 <= h1y1; h2x2 <= h2x1; h2y2 <= h2y1;
    rs2 <= rs1;
  end

  // Stage 3: dot and cross products
  logic v3;
  logic [31:0] a3, c3;
  logic signed [32:0] b3, k3;
  logic signed [33:0] d3, e3, cr13, cr23;
  logic signed [16:0] qx3, qy3;
  logic signed [15:0] h1x3, h1y3, h2x3, h2y3;
  logic [16:0] rs3;
  logic signed [32:0] a_sum, c_sum;
  assign a_sum = 33'(paa1) + 33'(paa2);
  assign c_sum = 33'(pcc1) + 33'(pcc2);
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    a3   <= a_sum[31:0];
    c3   <= c_sum[31:0];
    b3   <= 33'(pbb1) + 33'(pbb2);
    k3   <= 33'(pkk1) - 33'(pkk2);
    d3   <= 34'(pdd1) + 34'(pdd2);
    e3   <= 34'(pee1) + 34'(pee2);
    cr13 <= 34'(px11) - 34'(px12);
    cr23 <= 34'(px21) - 34'(px22);
    qx3 <= qx2; qy3 <= qy2;
    h1x3 <= h1x2; h1y3 <= h1y2; h2x3 <= h2x2; h2y3 <= h2y2;
    rs3 <= rs2;
  end

  // Stage 4: determinant
  logic v4;
  logic [63:0] det4;
  logic signed [65:0] det_full;
  logic signed [32:0] k4;
  logic signed [33:0] cr14, cr24;
  cpod_pkg::side_t sd4;
  assign det_full = 66'(k3) * 66'(k3);
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    det4 <= det_full[63:0];
    k4   <= k3;
    cr14 <= cr13;
    cr24 <= cr23;
    sd4.s     <= '0;
    sd4.t     <= '0;
    sd4.ft    <= 1'b0;
    sd4.need3 <= 1'b0;
    sd4.a <= a3; sd4.b <= b3; sd4.c <= c3; sd4.d <= d3; sd4.e <= e3;
    sd4.qx <= qx3; sd4.qy <= qy3;
    sd4.h1x <= h1x3; sd4.h1y <= h1y3; sd4.h2x <= h2x3; sd4.h2y <= h2y3;
    sd4.rsum <= rs3;
  end

  // General-case divisions: s = cr1/k, t = cr2/k (parallel flag rides along)
  logic par4;
  assign par4 = (det4 == '0) || (det4 < {32'b0, thr});

  logic d1_v, d2_v, d1_sat, d2_sat, d2_par;
  logic signed [17:0] d1_q, d2_q;
  logic [SW-1:0] d1_side;

  cpod_div #(.SIDE_W(SW)) u_div_s (
    .clk(clk), .rst(rst), .in_valid(v4),
    .num({{2{cr14[33]}}, cr14, 16'b0}), .den({k4[32], k4}),
    .side_in(sd4), .out_valid(d1_v), .quot(d1_q), .sat(d1_sat), .side_out(d1_side)
  );

  cpod_div #(.SIDE_W(1)) u_div_t (
    .clk(clk), .rst(rst), .in_valid(v4),
    .num({{2{cr24[33]}}, cr24, 16'b0}), .den({k4[32], k4}),
    .side_in(par4), .out_valid(d2_v), .quot(d2_q), .sat(d2_sat), .side_out(d2_par)
  );

  // Stage 5: pick s; parallel or saturated s needs t from the end point
  cpod_pkg::side_t in5, sd5;
  logic v5;
  logic signed [cpod_pkg::NUM_W-1:0] tnum5;
  always_comb begin
    in5 = cpod_pkg::side_t'(d1_side);
    if (d2_par) begin
      in5.s = in5.d[33] ? -cpod_pkg::ONE_Q16 : cpod_pkg::ONE_Q16;
    end else begin
      in5.s = d1_q;
    end
    in5.t     = d2_q;
    in5.ft    = d2_sat;
    in5.need3 = d2_par || d1_sat;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= d1_v && d2_v;
    end
    sd5 <= in5;
  end
  // s is +/-1 here whenever this quotient is used
  assign tnum5 = {{2{sd5.e[33]}}, sd5.e, 16'b0} +
                 (sd5.s[17] ? -{{3{sd5.b[32]}}, sd5.b, 16'b0}
                            :  {{3{sd5.b[32]}}, sd5.b, 16'b0});

  logic d3_v, d3_sat;
  logic signed [17:0] d3_q;
  logic [SW-1:0] d3_side;

  cpod_div #(.SIDE_W(SW)) u_div_te (
    .clk(clk), .rst(rst), .in_valid(v5),
    .num(tnum5), .den({2'b00, sd5.c}),
    .side_in(sd5), .out_valid(d3_v), .quot(d3_q), .sat(d3_sat), .side_out(d3_side)
  );

  // Stage 6: pick t; saturated t needs s recomputed from the end point
  cpod_pkg::side_t in6, sd6;
  logic v6;
  logic signed [cpod_pkg::NUM_W-1:0] snum6;
  always_comb begin
    in6 = cpod_pkg::side_t'(d3_side);
    if (in6.need3) begin
      in6.t  = d3_q;
      in6.ft = d3_sat;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= d3_v;
    end
    sd6 <= in6;
  end
  // t is +/-1 here whenever this quotient is used
  assign snum6 = (sd6.t[17] ? -{{3{sd6.b[32]}}, sd6.b, 16'b0}
                            :  {{3{sd6.b[32]}}, sd6.b, 16'b0}) -
                 {{2{sd6.d[33]}}, sd6.d, 16'b0};

  logic d4_v, d4_sat;
  logic signed [17:0] d4_q;
  logic [SW-1:0] d4_side;

  cpod_div #(.SIDE_W(SW)) u_div_se (
    .clk(clk), .rst(rst), .in_valid(v6),
    .num(snum6), .den({2'b00, sd6.a}),
    .side_in(sd6), .out_valid(d4_v), .quot(d4_q), .sat(d4_sat), .side_out(d4_side)
  );

  // Stage 7: final s and t
  cpod_pkg::side_t in7, sd7;
  logic v7;
  always_comb begin
    in7 = cpod_pkg::side_t'(d4_side);
    if (in7.ft) begin
      in7.s = d4_q;
    end
    in7.need3 = d4_sat;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= d4_v;
    end
    sd7 <= in7;
  end

  // Stage 8: parameter times half vectors
  logic v8;
  logic signed [33:0] sx8, sy8, tx8, ty8;
  logic signed [16:0] qx8, qy8;
  logic signed [17:0] s8, t8;
  logic [16:0] rs8;
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    sx8 <= 34'(sd7.s) * 34'(sd7.h1x);
    sy8 <= 34'(sd7.s) * 34'(sd7.h1y);
    tx8 <= 34'(sd7.t) * 34'(sd7.h2x);
    ty8 <= 34'(sd7.t) * 34'(sd7.h2y);
    qx8 <= sd7.qx; qy8 <= sd7.qy;
    s8 <= sd7.s; t8 <= sd7.t;
    rs8 <= sd7.rsum;
  end

  // Stage 9: difference vector, magnitude rounded half up
  logic v9;
  logic signed [35:0] dx, dy, ax, ay;
  logic [35:0] mx, my;
  logic [27:0] mx9, my9;
  logic signed [17:0] s9, t9;
  logic [16:0] rs9;
  always_comb begin
    dx = {{3{qx8[16]}}, qx8, 16'b0} + 36'(sx8) - 36'(tx8);
    dy = {{3{qy8[16]}}, qy8, 16'b0} + 36'(sy8) - 36'(ty8);
    ax = dx[35] ? -dx : dx;
    ay = dy[35] ? -dy : dy;
    mx = (36'(ax) + 36'd128) >> 8;
    my = (36'(ay) + 36'd128) >> 8;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    mx9 <= mx[27:0];
    my9 <= my[27:0];
    s9 <= s8; t9 <= t8; rs9 <= rs8;
  end

  // Stage 10: squares
  logic v10;
  logic [55:0] sqx10, sqy10;
  logic [33:0] rsq10;
  logic signed [17:0] s10, t10;
  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    sqx10 <= 56'(mx9) * 56'(mx9);
    sqy10 <= 56'(my9) * 56'(my9);
    rsq10 <= 34'(rs9) * 34'(rs9);
    s10 <= s9; t10 <= t9;
  end

  // Stage 11: round the sum, subtract radius term
  logic [56:0] sum_r;
  logic signed [41:0] gap;
  always_comb begin
    sum_r = (57'(sqx10) + 57'(sqy10) + 57'd32768) >> 16;
    gap   = $signed({1'b0, sum_r[40:0]}) - $signed({8'b0, rsq10});
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v10;
    end
    gap_measure  <= gap[36:0];
    first_param  <= s10;
    second_param <= t10;
  end

endmodule

// ----- tb/capsule_pair_overlap_distance_checker.sv -----
module capsule_pair_overlap_distance_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] first_center_x,
  input  logic signed [15:0] first_center_y,
  input  logic signed [15:0] first_half_x,
  input  logic signed [15:0] first_half_y,
  input  logic [15:0]        first_radius,
  input  logic signed [15:0] second_center_x,
  input  logic signed [15:0] second_center_y,
  input  logic signed [15:0] second_half_x,
  input  logic signed [15:0] second_half_y,
  input  logic [15:0]        second_radius,
  input  logic               done,
  input  logic signed [36:0] gap_measure,
  input  logic signed [17:0] first_param,
  input  logic signed [17:0] second_param,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 checked_count,
  output int                 clamp_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 65536;

  typedef struct packed {
    logic signed [36:0] gap;
    logic signed [17:0] s;
    logic signed [17:0] t;
  } gap_result_t;

  gap_result_t expected_gaps[$];
  logic [31:0] parallel_limit;

  // truncating Q1.16 quotient, saturated to [-1,1]; flag marks clamping
  function automatic longint clamp_quot(longint num, longint den, output int flag);
    longint lim;
    flag = 0;
    if (den == 0) return 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    lim = den * ONE;
    if (num > lim) begin
      flag = 1;
      return ONE;
    end
    if (num < -lim) begin
      flag = -1;
      return -ONE;
    end
    return num / den;
  endfunction

  function automatic longint unsigned round_square(longint x);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : longint'(x);
    m = (m + 128) >> 8;
    return m * m;
  endfunction

  function automatic gap_result_t predict_gap(
    longint p1x, longint p1y, longint h1x, longint h1y, longint r1,
    longint p2x, longint p2y, longint h2x, longint h2y, longint r2,
    logic [31:0] limit);
    longint qx, qy, a, b, c, d, e, k, s, t, dx, dy, sig;
    longint unsigned det, sum;
    int fs, ft;
    gap_result_t r;
    qx = p1x - p2x;
    qy = p1y - p2y;
    a = h1x * h1x + h1y * h1y;
    b = h1x * h2x + h1y * h2y;
    c = h2x * h2x + h2y * h2y;
    d = h1x * qx + h1y * qy;
    e = h2x * qx + h2y * qy;
    k = h1x * h2y - h1y * h2x;
    det = longint'(k * k);
    fs = 0;
    ft = 0;
    if (det == 0 || det < {32'd0, limit}) begin
      // nearly parallel: pin s to an end by the sign of d
      s = (d < 0) ? -ONE : ONE;
      t = clamp_quot(e * ONE + s * b, c, ft);
    end else begin
      s = clamp_quot((h2x * qy - h2y * qx) * ONE, k, fs);
      if (fs != 0) t = clamp_quot(e * ONE + s * b, c, ft);
      else t = clamp_quot((h1x * qy - h1y * qx) * ONE, k, ft);
    end
    if (ft != 0) s = clamp_quot(t * b - d * ONE, a, fs);
    dx = qx * ONE + s * h1x - t * h2x;
    dy = qy * ONE + s * h1y - t * h2y;
    sum = (round_square(dx) + round_square(dy) + 32768) >> 16;
    sig = r1 + r2;
    r.gap = 37'(longint'(sum) - sig * sig);
    r.s = 18'(s);
    r.t = 18'(t);
    return r;
  endfunction

  assign pending_count = expected_gaps.size();

  // requests in, threshold writes
  always @(posedge clk) begin
    if (rst) begin
      parallel_limit <= 32'd4295;
      expected_gaps.delete();
    end else begin
      if (cfg_valid && cfg_ready) parallel_limit <= cfg_data;
      if (start && !busy)
        expected_gaps.push_back(predict_gap(
          first_center_x, first_center_y, first_half_x, first_half_y,
          {48'd0, first_radius},
          second_center_x, second_center_y, second_half_x, second_half_y,
          {48'd0, second_radius}, parallel_limit));
    end
  end

  // results out
  always @(posedge clk) begin
    gap_result_t x;
    if (rst) begin
      fail_count <= 0;
      checked_count <= 0;
      clamp_count <= 0;
    end else if (done) begin
      if (expected_gaps.size() == 0) begin
        $error("result with no request waiting: gap %0d", gap_measure);
        fail_count <= fail_count + 1;
      end else begin
        x = expected_gaps.pop_front();
        checked_count <= checked_count + 1;
        if (x.s == 18'sd65536 || x.s == -18'sd65536 || x.t == 18'sd65536 ||
            x.t == -18'sd65536)
          clamp_count <= clamp_count + 1;
        if (gap_measure !== x.gap)
          $error("gap_measure: expected %0d, got %0d", x.gap, gap_measure);
        if (first_param !== x.s)
          $error("first_param: expected %0d, got %0d", x.s, first_param);
        if (second_param !== x.t)
          $error("second_param: expected %0d, got %0d", x.t, second_param);
        if (gap_measure !== x.gap || first_param !== x.s || second_param !== x.t)
          fail_count <= fail_count + 1;
      end
    end
  end

endmodule

// ----- tb/capsule_pair_overlap_distance_top_tb.sv -----
module capsule_pair_overlap_distance_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 65;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [15:0] p1x, p1y, h1x, h1y;
    logic [15:0]        r1;
    logic signed [15:0] p2x, p2y, h2x, h2y;
    logic [15:0]        r2;
  } capsule_pair_t;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  logic signed [15:0] first_center_x, first_center_y, first_half_x, first_half_y;
  logic signed [15:0] second_center_x, second_center_y, second_half_x, second_half_y;
  logic [15:0] first_radius, second_radius;
  logic signed [36:0] gap_measure;
  logic signed [17:0] first_param, second_param;
  logic [31:0] cfg_data;
  int fail_count, pending_count, checked_count, clamp_count;
  int cycles;
  int sent;
  bit idle_on;

  capsule_pair_overlap_distance_top DUT (.*);
  capsule_pair_overlap_distance_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6ns clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pair(capsule_pair_t p);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    first_center_x <= p.p1x;  first_center_y <= p.p1y;
    first_half_x <= p.h1x;    first_half_y <= p.h1y;
    first_radius <= p.r1;
    second_center_x <= p.p2x; second_center_y <= p.p2y;
    second_half_x <= p.h2x;   second_half_y <= p.h2y;
    second_radius <= p.r2;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
  endtask

  // quiesce, then write the threshold
  task automatic write_limit(logic [31:0] v);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] near(int span);
    return 16'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic capsule_pair_t make_pair(int mode);
    capsule_pair_t p;
    int m;
    p.p1x = 16'($urandom); p.p1y = 16'($urandom);
    p.h1x = 16'($urandom); p.h1y = 16'($urandom);
    p.p2x = 16'($urandom); p.p2y = 16'($urandom);
    p.h2x = 16'($urandom); p.h2y = 16'($urandom);
    p.r1 = 16'($urandom); p.r2 = 16'($urandom);
    if (mode >= 1) begin
      // close-range pairs: mostly in-range parameters and overlaps
      p.p1x = near(3000); p.p1y = near(3000); p.p2x = near(3000); p.p2y = near(3000);
      p.h1x = near(2000); p.h1y = near(2000); p.h2x = near(2000); p.h2y = near(2000);
      p.r1 = 16'($urandom_range(0, 1500)); p.r2 = 16'($urandom_range(0, 1500));
    end
    if (mode == 2) begin
      // parallel or near-parallel second segment
      m = $urandom_range(0, 6) - 3;
      p.h2x = 16'(p.h1x * m + int'($urandom_range(0, 2)) - 1);
      p.h2y = 16'(p.h1y * m);
    end
    if (mode == 3) begin
      // one segment degenerates to a point
      if ($urandom_range(0, 1)) begin p.h1x = 0; p.h1y = 0; end
      else begin p.h2x = 0; p.h2y = 0; end
    end
    return p;
  endfunction

  task automatic run_random(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      send_pair(make_pair(r < 2 ? 0 : r < 6 ? 1 : r < 9 ? 2 : 3));
    end
  endtask

  initial begin
    capsule_pair_t p;
    sent = 0;
    idle_on = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    first_center_x = 0; first_center_y = 0; first_half_x = 0; first_half_y = 0;
    first_radius = 0; second_center_x = 0; second_center_y = 0;
    second_half_x = 0; second_half_y = 0; second_radius = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: extremes, parallel, point-like and crossing cases
    p = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff,
          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff};
    send_pair(p);
    p = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'h0,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'h0};
    send_pair(p);
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};                send_pair(p);
    p = '{0, 0, 0, 0, 256, 512, 0, 0, 0, 256};          send_pair(p);
    p = '{0, 0, 0, 0, 100, 300, 200, 256, 0, 100};      send_pair(p);
    p = '{0, 0, 256, 0, 100, 0, 512, 0, 0, 100};        send_pair(p);
    p = '{0, 0, 256, 0, 100, 0, 512, 256, 0, 100};      send_pair(p);
    p = '{0, 0, 256, 0, 100, 0, 512, -256, 0, 100};     send_pair(p);
    p = '{0, 0, 256, 0, 100, 100, 0, 0, 256, 100};      send_pair(p);
    p = '{0, 0, 256, 0, 50, 2000, 300, 0, 256, 50};     send_pair(p);
    p = '{0, 0, 256, 0, 50, -2000, -300, 0, 256, 50};   send_pair(p);
    p = '{0, 0, 256, 0, 50, 200, 2000, 256, 0, 50};     send_pair(p);
    p = '{0, 0, 256, 256, 50, 256, 0, -256, 256, 50};   send_pair(p);
    p = '{0, 0, 1, 0, 0, 0, 0, 1, 1, 0};                send_pair(p);
    p = '{0, 0, 16'sh7fff, 0, 0, 0, 100, 0, 16'sh7fff, 0}; send_pair(p);
    p = '{16'sh7fff, 0, 1, 0, 0, 16'sh8000, 0, 0, 1, 0}; send_pair(p);

    run_random(180);
    write_limit(32'd0);
    send_pair('{0, 0, 256, 0, 10, 0, 512, 512, 0, 10});
    run_random(180);
    write_limit(32'hffff_ffff);
    run_random(180);
    write_limit($urandom);
    run_random(120);
    write_limit(32'd4295);
    idle_on = 1'b0;
    run_random(120);
    start <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("Sent %0d capsule pairs over five threshold settings (reset, 0, max, random).",
             sent);
    $display("Checked %0d results, %0d with a parameter clamped to an end.",
             checked_count, clamp_count);
    if (fail_count == 0 && pending_count == 0 && checked_count == sent) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cpod_pkg.sv
design/cpod_div.sv
design/capsule_pair_overlap_distance_top.sv
tb/capsule_pair_overlap_distance_checker.sv
tb/capsule_pair_overlap_distance_top_tb.sv
